>>> hdl/text_console_cell_writer_macros.svh
// ----------------------------------------------------------------------------
// Text console cell writer - assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console cell writer - package
// Command and internal op codes, character constants and the op type.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS    = 25;

   localparam int CMD_W  = 3;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;
   localparam int OP_W   = 3;

   localparam int QUEUE_DEPTH = 2;

   // host commands
   localparam logic [CMD_W-1:0] CMD_PUT   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ERASE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DRAW  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SET   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

   // classified ops handed from front to back
   localparam logic [OP_W-1:0] OP_NOP     = 3'd0;
   localparam logic [OP_W-1:0] OP_PUT     = 3'd1;
   localparam logic [OP_W-1:0] OP_NEWLINE = 3'd2;
   localparam logic [OP_W-1:0] OP_ERASE   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;
   localparam logic [OP_W-1:0] OP_DRAW    = 3'd5;
   localparam logic [OP_W-1:0] OP_SET     = 3'd6;
   localparam logic [OP_W-1:0] OP_READ    = 3'd7;

   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] MARK_CHAR    = 8'h5F;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

   typedef struct packed {
      logic [OP_W-1:0]   kind;
      logic [CHAR_W-1:0] chr;
   } tcw_op_type;

endpackage

`default_nettype wire

>>> hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// Text console cell writer - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/tcw_front.sv
// ----------------------------------------------------------------------------
// Text console cell writer - front end
// Takes request beats and classifies them into ops for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEFAULT_COLUMNS,
   parameter int ROWS    = DEFAULT_ROWS
) (
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [CMD_W-1:0]                       req_command,
   input  wire logic [CHAR_W-1:0]                      req_char_code,
   input  wire logic                                   req_cursor_visible,
   input  wire logic [$clog2(COLUMNS*ROWS+1)-1:0]      req_position,
   input  wire logic [$clog2(COLUMNS*ROWS+1)-1:0]      req_cell_index,
   input  wire logic                                   queue_full,
   input  wire logic                                   init_busy,
   output logic                                        push,
   output tcw_op_type                                  push_op,
   output logic      [$clog2(COLUMNS*ROWS+1)-1:0]      push_arg
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int POS_W      = $clog2(CELL_COUNT + 1);
   localparam logic [POS_W-1:0] N_POS = POS_W'(CELL_COUNT);

   assign req_stall = queue_full || init_busy;
   assign push      = req_valid && !req_stall;

   always_comb begin
      push_op.kind = OP_NOP;
      push_op.chr  = BLANK_CHAR;
      push_arg     = '0;
      case (req_command)
         CMD_PUT: begin
            push_op.kind = (req_char_code == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT;
            push_op.chr  = req_char_code;
         end
         CMD_ERASE: begin
            push_op.kind = OP_ERASE;
         end
         CMD_CLEAR: begin
            push_op.kind = OP_CLEAR;
         end
         CMD_DRAW: begin
            push_op.kind = OP_DRAW;
            push_op.chr  = req_cursor_visible ? MARK_CHAR : BLANK_CHAR;
         end
         CMD_SET: begin
            push_op.kind = OP_SET;
            push_arg     = (req_position > N_POS) ? N_POS : req_position;
         end
         CMD_READ: begin
            // off-screen reads answer zero without touching memory
            push_op.kind = (req_cell_index < N_POS) ? OP_READ : OP_NOP;
            push_arg     = req_cell_index;
         end
         default: begin
            push_op.kind = OP_NOP;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/tcw_queue.sv
// ----------------------------------------------------------------------------
// Text console cell writer - op queue
// Short FIFO between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue
   import tcw_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  head_valid,
   output logic      [WIDTH-1:0] head_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/tcw_back.sv
// ----------------------------------------------------------------------------
// Text console cell writer - back end
// Sequencer over the cell memory: writes, scroll, clear, cursor and reads.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_cell_writer_macros.svh"

module tcw_back
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEFAULT_COLUMNS,
   parameter int ROWS    = DEFAULT_ROWS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [ATTR_W-1:0]                  csr_wr_data,
   input  wire logic                               head_valid,
   input  wire tcw_op_type                         head_op,
   input  wire logic [$clog2(COLUMNS*ROWS+1)-1:0]  head_arg,
   output logic                                    pop,
   output logic                                    init_busy,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [CELL_W-1:0]                  rsp_cell_data,
   output logic      [$clog2(COLUMNS*ROWS+1)-1:0]  rsp_cursor_now
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int POS_W      = $clog2(CELL_COUNT + 1);
   localparam int LIN_W      = $clog2(CELL_COUNT + COLUMNS + 1);
   localparam int ROW_W      = $clog2(ROWS + 2);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int CNT_W      = 1;
   // row = (pos * RCP_MUL) >> RCP_SH, exact for every pos below 2**POS_W
   localparam int RCP_SH     = POS_W + COL_W;
   localparam int RCP_W      = POS_W + 2;
   localparam int PRD_W      = POS_W + RCP_W;

   localparam logic [LIN_W-1:0] N_LIN    = LIN_W'(CELL_COUNT);
   localparam logic [LIN_W-1:0] C_LIN    = LIN_W'(COLUMNS);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [POS_W-1:0] COPY_END = POS_W'(CELL_COUNT - COLUMNS);
   localparam logic [POS_W-1:0] N_SC     = POS_W'(CELL_COUNT);
   localparam logic [POS_W-1:0] LAST_SC  = POS_W'(CELL_COUNT - 1);
   localparam logic [RCP_W-1:0] RCP_MUL  = RCP_W'(((1 << RCP_SH) + COLUMNS - 1) / COLUMNS);
   localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(1);

   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] S_INIT   = 3'd0;
   localparam logic [STATE_W-1:0] S_IDLE   = 3'd1;
   localparam logic [STATE_W-1:0] S_FILL   = 3'd2;
   localparam logic [STATE_W-1:0] S_SCROLL = 3'd3;
   localparam logic [STATE_W-1:0] S_PUTW   = 3'd4;
   localparam logic [STATE_W-1:0] S_DIV    = 3'd5;
   localparam logic [STATE_W-1:0] S_READ   = 3'd6;
   localparam logic [STATE_W-1:0] S_DONE   = 3'd7;

   logic [STATE_W-1:0] state_ff, state_in;
   logic [LIN_W-1:0]   lin_ff, lin_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [POS_W-1:0]   sc_ff, sc_in;
   logic [ATTR_W-1:0]  color_ff, color_in;
   tcw_op_type         op_ff, op_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]   rsp_cursor_ff, rsp_cursor_in;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [CELL_W-1:0]  mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [CELL_W-1:0]  mem_rdata;

   logic               out_free;
   logic               finish;
   logic [CELL_W-1:0]  fin_data;
   logic [LIN_W-1:0]   scroll_src;
   logic [POS_W-1:0]   sc_prev;
   logic [PRD_W-1:0]   rcp_prod;
   logic [ROW_W-1:0]   quot;
   logic [LIN_W-1:0]   row_base;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign init_busy  = (state_ff == S_INIT);
   assign scroll_src = LIN_W'(sc_ff) + C_LIN;
   assign sc_prev    = sc_ff - POS_W'(1);
   assign rcp_prod   = PRD_W'(lin_ff[POS_W-1:0]) * PRD_W'(RCP_MUL);
   assign quot       = ROW_W'(rcp_prod >> RCP_SH);
   assign row_base   = LIN_W'(row_ff) * C_LIN;

   always_comb begin
      state_in  = state_ff;
      lin_in    = lin_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      sc_in     = sc_ff;
      color_in  = csr_wr_en ? csr_wr_data : color_ff;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      mem_we    = 1'b0;
      mem_waddr = lin_ff[ADDR_W-1:0];
      mem_wdata = {color_ff, op_ff.chr};
      mem_raddr = '0;
      pop       = 1'b0;
      finish    = 1'b0;
      fin_data  = '0;

      case (state_ff)
         S_INIT, S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = sc_ff[ADDR_W-1:0];
            mem_wdata = {(state_ff == S_INIT) ? RESET_ATTR : color_ff, BLANK_CHAR};
            if (sc_ff == LAST_SC) begin
               sc_in    = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end else begin
               sc_in = sc_ff + POS_W'(1);
            end
         end

         S_IDLE: begin
            if (head_valid && out_free) begin
               pop   = 1'b1;
               op_in = head_op;
               case (head_op.kind)
                  OP_PUT: begin
                     if (lin_ff == N_LIN) begin
                        sc_in    = '0;
                        state_in = S_SCROLL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_wdata = {color_ff, head_op.chr};
                        lin_in    = lin_ff + LIN_W'(1);
                        if (col_ff == LAST_COL) begin
                           col_in = '0;
                           row_in = row_ff + ROW_W'(1);
                        end else begin
                           col_in = col_ff + COL_W'(1);
                        end
                        state_in = S_DONE;
                     end
                  end
                  OP_NEWLINE: begin
                     lin_in = lin_ff - LIN_W'(col_ff) + C_LIN;
                     col_in = '0;
                     row_in = row_ff + ROW_W'(1);
                     if (row_ff >= LAST_ROW) begin
                        sc_in    = '0;
                        state_in = S_SCROLL;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  OP_ERASE: begin
                     if (lin_ff != '0) begin
                        lin_in    = lin_ff - LIN_W'(1);
                        mem_we    = 1'b1;
                        mem_waddr = ADDR_W'(lin_ff - LIN_W'(1));
                        mem_wdata = {color_ff, BLANK_CHAR};
                        if (col_ff == '0) begin
                           col_in = LAST_COL;
                           row_in = row_ff - ROW_W'(1);
                        end else begin
                           col_in = col_ff - COL_W'(1);
                        end
                     end
                     state_in = S_DONE;
                  end
                  OP_CLEAR: begin
                     lin_in   = '0;
                     row_in   = '0;
                     col_in   = '0;
                     sc_in    = '0;
                     state_in = S_FILL;
                  end
                  OP_DRAW: begin
                     if (lin_ff < N_LIN) begin
                        mem_we    = 1'b1;
                        mem_wdata = {color_ff, head_op.chr};
                     end
                     state_in = S_DONE;
                  end
                  OP_SET: begin
                     // row by reciprocal multiply, column on the next beat
                     lin_in   = LIN_W'(head_arg);
                     cnt_in   = CNT_INIT;
                     state_in = S_DIV;
                  end
                  OP_READ: begin
                     mem_raddr = head_arg[ADDR_W-1:0];
                     state_in  = S_READ;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SCROLL: begin
            // read row+1 ahead of its write, write it back one row up
            if (sc_ff < COPY_END) begin
               mem_raddr = scroll_src[ADDR_W-1:0];
            end
            if (sc_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = sc_prev[ADDR_W-1:0];
               mem_wdata = (sc_ff <= COPY_END) ? mem_rdata : {color_ff, BLANK_CHAR};
            end
            if (sc_ff == N_SC) begin
               sc_in    = '0;
               lin_in   = lin_ff - C_LIN;
               row_in   = row_ff - ROW_W'(1);
               state_in = (op_ff.kind == OP_PUT) ? S_PUTW : S_DONE;
            end else begin
               sc_in = sc_ff + POS_W'(1);
            end
         end

         S_PUTW: begin
            mem_we = 1'b1;
            lin_in = lin_ff + LIN_W'(1);
            if (col_ff == LAST_COL) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
            state_in = S_DONE;
         end

         S_DIV: begin
            if (cnt_ff != '0) begin
               row_in = quot;
               cnt_in = '0;
            end else begin
               col_in   = COL_W'(lin_ff - row_base);
               state_in = S_DONE;
            end
         end

         S_READ: begin
            finish   = 1'b1;
            fin_data = mem_rdata;
            state_in = S_IDLE;
         end

         S_DONE: begin
            finish   = 1'b1;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_cursor_in = rsp_cursor_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = fin_data;
         rsp_cursor_in = lin_ff[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         lin_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         sc_ff        <= '0;
         color_ff     <= RESET_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lin_ff       <= lin_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         sc_ff        <= sc_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cnt_ff        <= cnt_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_cursor_ff <= rsp_cursor_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_data  = rsp_data_ff;
   assign rsp_cursor_now = rsp_cursor_ff;

   `TCW_ASSERT_IMPL(a_cursor_range, state_ff == S_IDLE, lin_ff <= N_LIN,
                    "cursor past screen end")
   `TCW_ASSERT_IMPL(a_row_col_match, state_ff == S_IDLE,
                    (row_base + LIN_W'(col_ff)) == lin_ff,
                    "row/column out of step with cursor")
   `TCW_ASSERT_IMPL(a_write_in_range, mem_we, LIN_W'(mem_waddr) < N_LIN,
                    "cell write outside screen")
   `TCW_ASSERT_IMPL(a_result_slot_free, finish, out_free,
                    "result overwrites a pending beat")
   `TCW_ASSERT_NEXT(a_no_pop_in_init, state_ff == S_INIT, !pop,
                    "op taken during clearing pass")

endmodule

`default_nettype wire

>>> hdl/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// Text console cell writer - top level
// COLUMNS x ROWS screen of attribute/character cells with a linear cursor.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the cell memory
// (COLUMNS*ROWS cells, 2000 by default), one cell a cycle, with req_stall high;
// csr writes are taken throughout. Every command returns one result beat,
// registered the cycle after the back end finishes it. Put, erase, draw cursor,
// newline, read and unused commands are taken in the idle state and finish in
// the done or read state; set cursor first does a reciprocal multiply for the
// row, then the column. Clear writes every cell and a scroll copies each row
// one row up and blanks the last (then writes the character of a put), both
// through the single write port of the cell memory. A two-beat queue lets
// requests be taken while a result beat waits on rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEFAULT_COLUMNS,
   parameter int ROWS    = DEFAULT_ROWS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [ATTR_W-1:0]                     csr_wr_data,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [CMD_W-1:0]                      req_command,
   input  wire logic [CHAR_W-1:0]                     req_char_code,
   input  wire logic                                  req_cursor_visible,
   input  wire logic [$clog2(COLUMNS*ROWS+1)-1:0]     req_position,
   input  wire logic [$clog2(COLUMNS*ROWS+1)-1:0]     req_cell_index,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [CELL_W-1:0]                     rsp_cell_data,
   output logic      [$clog2(COLUMNS*ROWS+1)-1:0]     rsp_cursor_now
);

   localparam int POS_W  = $clog2(COLUMNS * ROWS + 1);
   localparam int OPB_W  = $bits(tcw_op_type);
   localparam int Q_W    = OPB_W + POS_W;

   logic             queue_full;
   logic             init_busy;
   logic             push;
   tcw_op_type       push_op;
   logic [POS_W-1:0] push_arg;
   logic             pop;
   logic             head_valid;
   logic [Q_W-1:0]   head_data;
   tcw_op_type       head_op;
   logic [POS_W-1:0] head_arg;

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_char_code      (req_char_code),
      .req_cursor_visible (req_cursor_visible),
      .req_position       (req_position),
      .req_cell_index     (req_cell_index),
      .queue_full         (queue_full),
      .init_busy          (init_busy),
      .push               (push),
      .push_op            (push_op),
      .push_arg           (push_arg)
   );

   tcw_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_op, push_arg}),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign head_op  = tcw_op_type'(head_data[Q_W-1 -: OPB_W]);
   assign head_arg = head_data[POS_W-1:0];

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .head_valid     (head_valid),
      .head_op        (head_op),
      .head_arg       (head_arg),
      .pop            (pop),
      .init_busy      (init_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_data  (rsp_cell_data),
      .rsp_cursor_now (rsp_cursor_now)
   );

endmodule

`default_nettype wire
